// ===== rtl/utf16_to_utf8_transcoder_assert.svh =====
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 transcoder assertion macros
// Implication checks shared by the transcoder modules.
// ----------------------------------------------------------------------------
`ifndef UTF16_TO_UTF8_TRANSCODER_ASSERT_SVH
`define UTF16_TO_UTF8_TRANSCODER_ASSERT_SVH

`ifndef ASSERT_OFF

`define UTT_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`define UTT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define UTT_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)

`define UTT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

// ===== rtl/utt_pkg.sv =====
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 transcoder package
// Job record passed from front to back, queue sizing and UTF-8 encoding.
// ----------------------------------------------------------------------------
package utt_pkg;

  localparam int unsigned CpW     = 21;
  localparam int unsigned QDepth  = 4;
  localparam int unsigned QPtrW   = $clog2(QDepth);
  localparam int unsigned QCntW   = $clog2(QDepth + 1);

  localparam logic [5:0]     HighTag     = 6'h36;
  localparam logic [5:0]     LowTag      = 6'h37;
  localparam logic [10:0]    PairOffset  = 11'h040;
  localparam logic [CpW-1:0] Replacement = 21'h00FFFD;
  localparam logic [CpW-1:0] Lim1        = 21'h000080;
  localparam logic [CpW-1:0] Lim2        = 21'h000800;
  localparam logic [CpW-1:0] Lim3        = 21'h010000;
  localparam logic [7:0]     Lead2       = 8'hC0;
  localparam logic [7:0]     Lead3       = 8'hE0;
  localparam logic [7:0]     Lead4       = 8'hF0;
  localparam logic [7:0]     ContTag     = 8'h80;

  typedef struct packed {
    logic           pre_fffd;
    logic           has_cp;
    logic [CpW-1:0] cp;
    logic           last;
  } job_t;

  function automatic logic [2:0] utf8_len(input logic [CpW-1:0] cp);
    logic [2:0] n;
    if (cp < Lim1) n = 3'd1;
    else if (cp < Lim2) n = 3'd2;
    else if (cp < Lim3) n = 3'd3;
    else n = 3'd4;
    return n;
  endfunction

  function automatic logic [7:0] utf8_byte(input logic [CpW-1:0] cp, input logic [1:0] k);
    logic [7:0] b;
    b = 8'h00;
    if (cp < Lim1) begin
      b = cp[7:0];
    end else if (cp < Lim2) begin
      case (k)
        2'd0:    b = Lead2 | {3'b000, cp[10:6]};
        default: b = ContTag | {2'b00, cp[5:0]};
      endcase
    end else if (cp < Lim3) begin
      case (k)
        2'd0:    b = Lead3 | {4'b0000, cp[15:12]};
        2'd1:    b = ContTag | {2'b00, cp[11:6]};
        default: b = ContTag | {2'b00, cp[5:0]};
      endcase
    end else begin
      case (k)
        2'd0:    b = Lead4 | {5'b00000, cp[20:18]};
        2'd1:    b = ContTag | {2'b00, cp[17:12]};
        2'd2:    b = ContTag | {2'b00, cp[11:6]};
        default: b = ContTag | {2'b00, cp[5:0]};
      endcase
    end
    return b;
  endfunction

endpackage

// ===== rtl/utf16_to_utf8_transcoder.sv =====
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 transcoder
// Converts a stream of UTF-16 code units into a stream of UTF-8 bytes.
// ----------------------------------------------------------------------------
// Input channel: in_valid/in_ready with code_unit and last_unit; last_unit
// marks the final unit of a string and flushes any pending high surrogate.
// Output channel: out_valid/out_ready with out_byte, run_end on the last byte
// caused by one input unit, and string_end on the final byte of a string.
// Each accepted unit yields 0 to 6 bytes: a held high surrogate yields none,
// an ordinary unit 1 to 3, a surrogate pair 4, unpaired surrogates EF BF BD.
// A unit's job passes the queue and the emitter's current-job register before its first byte is registered out.
// Throughput: one byte per cycle while the receiver accepts, set by the single
// output register; a 4-entry job queue lets units keep arriving while earlier
// bytes drain.
// Reset clears the pending surrogate, the queue and the output register.
// When the receiver stalls, the output byte holds, the emitter holds, and
// in_ready drops once the job queue is full.
// ----------------------------------------------------------------------------
module utf16_to_utf8_transcoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] code_unit,
  input  logic        last_unit,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        run_end,
  output logic        string_end
);
  import utt_pkg::*;

  logic q_push;
  logic q_pop;
  logic q_full;
  logic q_empty;
  job_t q_in;
  job_t q_head;

  utt_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .code_unit (code_unit),
    .last_unit (last_unit),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_in)
  );

  utt_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .full      (q_full),
    .empty     (q_empty),
    .head      (q_head)
  );

  utt_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .run_end    (run_end),
    .string_end (string_end)
  );

endmodule

// ===== rtl/utt_front.sv =====
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 transcoder front end
// Accepts code units, pairs surrogates and queues one encoding job per unit that yields bytes.
// ----------------------------------------------------------------------------
module utt_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [15:0]   code_unit,
  input  logic          last_unit,
  input  logic          q_full,
  output logic          q_push,
  output utt_pkg::job_t q_data
);
  import utt_pkg::*;

  logic       held_valid;
  logic [9:0] held_bits;
  logic       accept;
  logic       is_high;
  logic       is_low;
  logic       pair;
  logic [10:0] pair_hi;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign is_high  = (code_unit[15:10] == HighTag);
  assign is_low   = (code_unit[15:10] == LowTag);
  assign pair     = held_valid && is_low;
  assign pair_hi  = {1'b0, held_bits} + PairOffset;

  always_comb begin
    q_data.last     = last_unit;
    q_data.pre_fffd = held_valid && !is_low;
    q_data.has_cp   = 1'b1;
    q_data.cp       = {5'b00000, code_unit};
    if (pair) begin
      q_data.cp = {pair_hi, code_unit[9:0]};
    end else if (is_high) begin
      q_data.has_cp = last_unit;
      q_data.cp     = Replacement;
    end else if (is_low) begin
      q_data.cp = Replacement;
    end
  end

  assign q_push = accept && (q_data.pre_fffd || q_data.has_cp);

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
      held_bits  <= 10'd0;
    end else if (accept) begin
      if (!pair && is_high && !last_unit) begin
        held_valid <= 1'b1;
        held_bits  <= code_unit[9:0];
      end else begin
        held_valid <= 1'b0;
        held_bits  <= 10'd0;
      end
    end
  end

endmodule

// ===== rtl/utt_queue.sv =====
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 transcoder job queue
// Small register FIFO that decouples the front end from the byte emitter.
// ----------------------------------------------------------------------------
`include "utf16_to_utf8_transcoder_assert.svh"

module utt_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  utt_pkg::job_t push_data,
  input  logic          pop,
  output logic          full,
  output logic          empty,
  output utt_pkg::job_t head
);
  import utt_pkg::*;

  job_t             slots [QDepth];
  logic [QPtrW-1:0] wptr;
  logic [QPtrW-1:0] rptr;
  logic [QCntW-1:0] count;

  assign full  = (count == QCntW'(QDepth));
  assign empty = (count == '0);
  assign head  = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop) rptr <= rptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  `UTT_ASSERT_IMP(a_no_overflow, clk, rst, push, !full, "push into full queue")
  `UTT_ASSERT_IMP(a_no_underflow, clk, rst, pop, !empty, "pop from empty queue")
  `UTT_ASSERT_NEXT(a_count_push, clk, rst, push && !pop, count == $past(count) + 1'b1,
                   "queue count did not advance on push")

endmodule

// ===== rtl/utt_back.sv =====
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 transcoder back end
// Pops jobs and emits their UTF-8 bytes through an output register, one per cycle while the receiver accepts.
// ----------------------------------------------------------------------------
`include "utf16_to_utf8_transcoder_assert.svh"

module utt_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_empty,
  input  utt_pkg::job_t q_head,
  output logic          q_pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_byte,
  output logic          run_end,
  output logic          string_end
);
  import utt_pkg::*;

  job_t       cur;
  logic       cur_valid;
  logic [2:0] idx;
  logic [2:0] pre_n;
  logic [2:0] cp_n;
  logic [2:0] total;
  logic [2:0] k;
  logic       in_pre;
  logic       at_end;
  logic       out_free;
  logic       step;
  logic [7:0] byte_sel;

  assign pre_n    = cur.pre_fffd ? 3'd3 : 3'd0;
  assign cp_n     = cur.has_cp ? utf8_len(cur.cp) : 3'd0;
  assign total    = pre_n + cp_n;
  assign k        = idx - pre_n;
  assign in_pre   = cur.pre_fffd && (idx < 3'd3);
  assign byte_sel = in_pre ? utf8_byte(Replacement, idx[1:0]) : utf8_byte(cur.cp, k[1:0]);
  assign at_end   = (idx == total - 3'd1);
  assign out_free = !out_valid || out_ready;
  assign step     = cur_valid && out_free;
  assign q_pop    = !q_empty && (!cur_valid || (step && at_end));

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= 3'd0;
      out_valid <= 1'b0;
    end else begin
      if (step) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      if (q_pop) begin
        cur_valid <= 1'b1;
        idx       <= 3'd0;
      end else if (step) begin
        if (at_end) cur_valid <= 1'b0;
        else idx <= idx + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) cur <= q_head;
    if (step) begin
      out_byte   <= byte_sel;
      run_end    <= at_end;
      string_end <= at_end && cur.last;
    end
  end

  `UTT_ASSERT_IMP(a_idx_range, clk, rst, cur_valid, idx < total, "byte index past job end")
  `UTT_ASSERT_IMP(a_end_order, clk, rst, out_valid && string_end, run_end,
                  "string end without run end")
  `UTT_ASSERT_IMP(a_job_nonempty, clk, rst, cur_valid, total != 3'd0, "empty job in emitter")

endmodule

// ===== tb/sv/utf16_to_utf8_transcoder_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 transcoder testbench
// Drives code units with random gaps and random receiver stalls. A scoreboard
// encodes each accepted unit into the UTF-8 bytes it should produce, tracking
// pending high surrogates, and checks every output byte with its run and
// string markers. A short directed sequence covers range edges, pairs and
// unpaired surrogates. The random part mixes mostly well-formed strings with
// broken strings and raw noise.
// ----------------------------------------------------------------------------
module utf16_to_utf8_transcoder_tb;

  typedef enum logic [2:0] {
    K_ASCII,
    K_TWO_BYTE,
    K_THREE_BYTE,
    K_PAIR,
    K_HIGH,
    K_LOW
  } unit_kind_t;

  class utf8_scoreboard;
    typedef struct packed {
      logic [7:0] value;
      logic       run_end;
      logic       string_end;
    } utf8_out_t;

    utf8_out_t   expected_bytes[$];
    logic [7:0]  unit_bytes[$];
    logic [9:0]  held_bits;
    logic        held_valid;
    int unsigned mismatches;
    int unsigned bytes_checked;
    int unsigned units_noted;
    int unsigned pairs_formed;
    int unsigned replacements;

    function new();
      held_bits     = '0;
      held_valid    = 1'b0;
      mismatches    = 0;
      bytes_checked = 0;
      units_noted   = 0;
      pairs_formed  = 0;
      replacements  = 0;
    endfunction

    function void append_byte(input logic [7:0] b);
      unit_bytes.insert(unit_bytes.size(), b);
    endfunction

    function void encode_point(input logic [20:0] cp);
      if (cp < 21'h80) begin
        append_byte(cp[7:0]);
      end else if (cp < 21'h800) begin
        append_byte(8'hC0 | {3'b000, cp[10:6]});
        append_byte(8'h80 | {2'b00, cp[5:0]});
      end else if (cp < 21'h10000) begin
        append_byte(8'hE0 | {4'b0000, cp[15:12]});
        append_byte(8'h80 | {2'b00, cp[11:6]});
        append_byte(8'h80 | {2'b00, cp[5:0]});
      end else begin
        append_byte(8'hF0 | {5'b00000, cp[20:18]});
        append_byte(8'h80 | {2'b00, cp[17:12]});
        append_byte(8'h80 | {2'b00, cp[11:6]});
        append_byte(8'h80 | {2'b00, cp[5:0]});
      end
    endfunction

    function void encode_replacement();
      replacements++;
      encode_point(21'h00FFFD);
    endfunction

    function void note_unit(input logic [15:0] unit, input logic last_flag);
      logic      is_high;
      logic      is_low;
      utf8_out_t entry;
      is_high = (unit >= 16'hD800) && (unit < 16'hDC00);
      is_low  = (unit >= 16'hDC00) && (unit <= 16'hDFFF);
      units_noted++;
      unit_bytes.delete();
      if (held_valid && is_low) begin
        pairs_formed++;
        encode_point(21'h10000 + {1'b0, held_bits, unit[9:0]});
        held_valid = 1'b0;
        held_bits  = '0;
      end else begin
        if (held_valid) begin
          held_valid = 1'b0;
          held_bits  = '0;
          encode_replacement();
        end
        if (is_high) begin
          if (last_flag) begin
            encode_replacement();
          end else begin
            held_bits  = unit[9:0];
            held_valid = 1'b1;
          end
        end else if (is_low) begin
          encode_replacement();
        end else begin
          encode_point({5'b00000, unit});
        end
      end
      foreach (unit_bytes[k]) begin
        entry.value      = unit_bytes[k];
        entry.run_end    = (k == unit_bytes.size() - 1);
        entry.string_end = (k == unit_bytes.size() - 1) && last_flag;
        expected_bytes.insert(expected_bytes.size(), entry);
      end
    endfunction

    function void check_byte(input logic [7:0] value, input logic run_end,
                             input logic string_end);
      utf8_out_t exp;
      if (expected_bytes.size() == 0) begin
        $error("unexpected byte %h (run_end %b, string_end %b)", value, run_end, string_end);
        mismatches++;
        return;
      end
      exp = expected_bytes.pop_front();
      bytes_checked++;
      if (value !== exp.value) begin
        $error("out_byte: expected %h, got %h", exp.value, value);
        mismatches++;
      end
      if (run_end !== exp.run_end) begin
        $error("run_end: expected %b, got %b", exp.run_end, run_end);
        mismatches++;
      end
      if (string_end !== exp.string_end) begin
        $error("string_end: expected %b, got %b", exp.string_end, string_end);
        mismatches++;
      end
    endfunction

    function void close_out();
      if (expected_bytes.size() != 0) begin
        $error("%0d expected bytes never arrived", expected_bytes.size());
        mismatches++;
      end
    endfunction
  endclass

  logic        clk        = 1'b0;
  logic        rst        = 1'b1;
  logic        in_valid   = 1'b0;
  logic        in_ready;
  logic [15:0] code_unit  = '0;
  logic        last_unit  = 1'b0;
  logic        out_valid;
  logic        out_ready  = 1'b0;
  logic [7:0]  out_byte;
  logic        run_end;
  logic        string_end;

  utf8_scoreboard sb = new();

  logic        rx_free  = 1'b0;
  logic        tx_burst = 1'b0;
  int unsigned rx_hold  = 0;
  int unsigned units_sent = 0;
  int unsigned strings_sent = 0;

  logic [16:0] directed_seq [24] = '{
    {1'b0, 16'h0000}, {1'b0, 16'h007F}, {1'b0, 16'h0080}, {1'b0, 16'h07FF},
    {1'b0, 16'h0800}, {1'b0, 16'hD7FF}, {1'b0, 16'hE000}, {1'b1, 16'hFFFF},
    {1'b0, 16'hD800}, {1'b0, 16'hDC00}, {1'b0, 16'hDBFF}, {1'b1, 16'hDFFF},
    {1'b1, 16'hD83D},
    {1'b0, 16'hDABC}, {1'b0, 16'h0041},
    {1'b0, 16'hD900}, {1'b0, 16'hDA00}, {1'b0, 16'hDE00},
    {1'b0, 16'hDC80},
    {1'b0, 16'hD801}, {1'b1, 16'h0000},
    {1'b1, 16'hDD00},
    {1'b0, 16'hD802}, {1'b1, 16'hDBFF}
  };

  utf16_to_utf8_transcoder u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .code_unit  (code_unit),
    .last_unit  (last_unit),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .run_end    (run_end),
    .string_end (string_end)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rx_free) begin
      out_ready <= 1'b1;
    end else if (rx_hold > 0) begin
      out_ready <= 1'b0;
      rx_hold = rx_hold - 1;
    end else begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3: begin
          rx_hold = $urandom_range(0, 2);
          out_ready <= 1'b0;
        end
        4: begin
          rx_hold = $urandom_range(10, 40);
          out_ready <= 1'b0;
        end
        default: out_ready <= 1'b1;
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      sb.check_byte(out_byte, run_end, string_end);
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (tx_burst || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [15:0] rand_unit(input unit_kind_t kind);
    case (kind)
      K_ASCII:      return 16'($urandom_range(16'h0000, 16'h007F));
      K_TWO_BYTE:   return 16'($urandom_range(16'h0080, 16'h07FF));
      K_THREE_BYTE: begin
        if ($urandom_range(0, 1)) return 16'($urandom_range(16'h0800, 16'hD7FF));
        return 16'($urandom_range(16'hE000, 16'hFFFF));
      end
      K_HIGH:       return 16'($urandom_range(16'hD800, 16'hDBFF));
      K_LOW:        return 16'($urandom_range(16'hDC00, 16'hDFFF));
      default:      return 16'($urandom_range(16'h0000, 16'hFFFF));
    endcase
  endfunction

  function automatic unit_kind_t pick_kind(input bit broken);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!broken) begin
      if (r < 30) return K_ASCII;
      if (r < 50) return K_TWO_BYTE;
      if (r < 75) return K_THREE_BYTE;
      return K_PAIR;
    end
    if (r < 20) return K_ASCII;
    if (r < 30) return K_TWO_BYTE;
    if (r < 45) return K_THREE_BYTE;
    if (r < 60) return K_PAIR;
    if (r < 82) return K_HIGH;
    return K_LOW;
  endfunction

  task automatic send_unit(input logic [15:0] unit, input logic last_flag);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    code_unit <= unit;
    last_unit <= last_flag;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_unit(unit, last_flag);
    units_sent++;
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.expected_bytes.size() != 0);
  endtask

  task automatic send_string(input int unsigned len, input bit broken);
    unit_kind_t kind;
    for (int i = 0; i < len; i++) begin
      kind = pick_kind(broken);
      if (kind == K_PAIR) begin
        send_unit(rand_unit(K_HIGH), 1'b0);
        send_unit(rand_unit(K_LOW), i == len - 1);
      end else begin
        send_unit(rand_unit(kind), i == len - 1);
      end
    end
    strings_sent++;
  endtask

  initial begin
    int unsigned r;
    int unsigned drain_cycles;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_seq[i]) send_unit(directed_seq[i][15:0], directed_seq[i][16]);
    wait_for_drain();

    while (units_sent < 355) begin
      tx_burst <= ($urandom_range(0, 3) == 0);
      rx_free  <= ($urandom_range(0, 4) == 0);
      r = $urandom_range(0, 99);
      if (r < 65) begin
        send_string($urandom_range(1, 8), 1'b0);
      end else if (r < 88) begin
        send_string($urandom_range(1, 6), 1'b1);
      end else begin
        repeat ($urandom_range(1, 4)) begin
          send_unit(16'($urandom_range(16'h0000, 16'hFFFF)), 1'($urandom_range(0, 1)));
        end
      end
      if ($urandom_range(0, 14) == 0) wait_for_drain();
    end
    in_valid <= 1'b0;

    drain_cycles = 0;
    while (sb.expected_bytes.size() != 0 && drain_cycles < 50000) begin
      @(posedge clk);
      drain_cycles++;
    end
    repeat (8) @(posedge clk);
    sb.close_out();

    $display("Sent %0d code units in %0d strings plus directed and noise units.",
             units_sent, strings_sent);
    $display("Checked %0d bytes: %0d surrogate pairs, %0d replacement characters.",
             sb.bytes_checked, sb.pairs_formed, sb.replacements);
    if (sb.mismatches == 0) begin
      $display("PASS utf16_to_utf8_transcoder");
    end else begin
      $display("FAIL utf16_to_utf8_transcoder");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAIL utf16_to_utf8_transcoder");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/utt_pkg.sv
rtl/utt_front.sv
rtl/utt_queue.sv
rtl/utt_back.sv
rtl/utf16_to_utf8_transcoder.sv
tb/sv/utf16_to_utf8_transcoder_tb.sv
